/* hdl/knh_pkg.sv */
package knh_pkg;

  localparam int MAX_NEIGHBORS_DEF = 16;
  localparam int ID_BITS_DEF       = 20;

  localparam int DIST_W  = 31;
  localparam int CNT_W   = 5;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [DIST_W-1:0] FAR_BITS = 31'd1900671690;
  localparam logic [CNT_W-1:0]  NEIGHBOR_COUNT_RESET = 5'd16;

  localparam logic REG_NEIGHBOR_COUNT = 1'b0;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } store_cmd_t;

endpackage

/* hdl/knh_in_if.sv */
interface knh_in_if #(
  parameter int ID_BITS = knh_pkg::ID_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic [ID_BITS-1:0]         candidate_id;
  logic [knh_pkg::DIST_W-1:0] distance;
  logic                       first;
  logic                       last;

  modport source (output valid, candidate_id, distance, first, last, input ready);
  modport sink (input valid, candidate_id, distance, first, last, output ready);
endinterface

/* hdl/knh_out_if.sv */
interface knh_out_if #(
  parameter int ID_BITS = knh_pkg::ID_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic                       accepted;
  logic                       is_entry;
  logic [ID_BITS-1:0]         entry_id;
  logic [knh_pkg::DIST_W-1:0] entry_distance;
  logic                       entry_new;
  logic                       last_of_run;

  modport source (
    output valid, accepted, is_entry, entry_id, entry_distance, entry_new, last_of_run,
    input ready
  );
  modport sink (
    input valid, accepted, is_entry, entry_id, entry_distance, entry_new, last_of_run,
    output ready
  );
endinterface

/* hdl/knh_ram.sv */
module knh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  logic [WIDTH-1:0]          wr_data,
  input  logic                      rd_en,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr,
  output logic [WIDTH-1:0]          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/knh_store.sv */
module knh_store #(
  parameter int MAX_NEIGHBORS = knh_pkg::MAX_NEIGHBORS_DEF,
  parameter int ID_BITS       = knh_pkg::ID_BITS_DEF,
  localparam int EW         = knh_pkg::DIST_W + ID_BITS + 1,
  localparam int SLOT_W     = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1,
  localparam int BANK_DEPTH = (MAX_NEIGHBORS > 2) ? (MAX_NEIGHBORS + 1) / 2 : 2,
  localparam int BI_W       = $clog2(BANK_DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  knh_pkg::store_cmd_t cmd,
  input  logic [BI_W-1:0]     rd_even_idx,
  input  logic [BI_W-1:0]     rd_odd_idx,
  input  logic [SLOT_W-1:0]   wr_slot,
  input  logic [EW-1:0]       wr_data,
  output logic [EW-1:0]       rd_even_data,
  output logic [EW-1:0]       rd_odd_data
);

  localparam logic [EW-1:0] EMPTY_ENTRY = {knh_pkg::FAR_BITS, {ID_BITS{1'b1}}, 1'b1};

  logic [BANK_DEPTH-1:0] valid_even;
  logic [BANK_DEPTH-1:0] valid_odd;
  logic                  ok_even;
  logic                  ok_odd;
  logic [SLOT_W:0]       wr_idx_w;
  logic [BI_W-1:0]       wr_idx;
  logic                  wr_even;
  logic                  wr_odd;
  logic [EW-1:0]         q_even;
  logic [EW-1:0]         q_odd;

  assign wr_idx_w = {1'b0, wr_slot} >> 1;
  assign wr_idx   = wr_idx_w[BI_W-1:0];
  assign wr_even  = cmd.wr_en && !wr_slot[0];
  assign wr_odd   = cmd.wr_en && wr_slot[0];

  knh_ram #(.WIDTH(EW), .DEPTH(BANK_DEPTH)) u_even (
    .clk     (clk),
    .wr_en   (wr_even),
    .wr_addr (wr_idx),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_even_idx),
    .rd_data (q_even)
  );

  knh_ram #(.WIDTH(EW), .DEPTH(BANK_DEPTH)) u_odd (
    .clk     (clk),
    .wr_en   (wr_odd),
    .wr_addr (wr_idx),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_odd_idx),
    .rd_data (q_odd)
  );

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      valid_even <= '0;
      valid_odd  <= '0;
      ok_even    <= 1'b0;
      ok_odd     <= 1'b0;
    end else begin
      if (wr_even) begin
        valid_even[wr_idx] <= 1'b1;
      end
      if (wr_odd) begin
        valid_odd[wr_idx] <= 1'b1;
      end
      if (cmd.rd_en) begin
        ok_even <= valid_even[rd_even_idx];
        ok_odd  <= valid_odd[rd_odd_idx];
      end
    end
  end

  assign rd_even_data = ok_even ? q_even : EMPTY_ENTRY;
  assign rd_odd_data  = ok_odd ? q_odd : EMPTY_ENTRY;

endmodule

/* hdl/k_nearest_bounded_max_heap.sv */
// Channel  Port    Dir  Payload
// offer    offer   in   candidate_id, distance, first, last
// result   result  out  accepted, is_entry, entry_id, entry_distance, entry_new, last_of_run
// config   APB     in   neighbor_count at byte address 0
//
// Transaction steps: accept, a duplicate scan over the k heap slots, a sift when the candidate
// is taken (at most floor(log2(k)) moves), the result, and a readout of all k slots when
// last is set; an empty id skips scan and sift. Each heap bank has a single read port:
// the duplicate scan reads two slots a cycle, the sift reads both children a cycle.
// Reset: synchronous; heap slots read as empty through cleared valid bits, k resets to 16.
// Stalls: one output register; a stalled result holds the sequencer in its result states,
// and offer ready stays low until the sequencer is back in idle.
module k_nearest_bounded_max_heap #(
  parameter int MAX_NEIGHBORS = knh_pkg::MAX_NEIGHBORS_DEF,
  parameter int ID_BITS       = knh_pkg::ID_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  knh_in_if.sink                        offer,
  knh_out_if.source                     result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [knh_pkg::PADDR_W-1:0]   paddr,
  input  logic [knh_pkg::PDATA_W-1:0]   pwdata,
  output logic [knh_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int DW         = knh_pkg::DIST_W;
  localparam int EW         = DW + ID_BITS + 1;
  localparam int SLOT_W     = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int BANK_DEPTH = (MAX_NEIGHBORS > 2) ? (MAX_NEIGHBORS + 1) / 2 : 2;
  localparam int BI_W       = $clog2(BANK_DEPTH);
  localparam int K_W        = $clog2(MAX_NEIGHBORS + 1);
  localparam int CW         = ($clog2(MAX_NEIGHBORS + 1) + 2 > 6) ?
                              $clog2(MAX_NEIGHBORS + 1) + 2 : 6;
  localparam logic [ID_BITS-1:0] EMPTY_ID = {ID_BITS{1'b1}};

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_SIFT    = 3'd2;
  localparam logic [2:0] S_RESULT  = 3'd3;
  localparam logic [2:0] S_RD_WAIT = 3'd4;

  logic [2:0]                state;
  logic [knh_pkg::CNT_W-1:0] neighbor_count;
  logic [ID_BITS-1:0]        cand_id;
  logic [DW-1:0]             cand_dist;
  logic                      last_q;
  logic [K_W-1:0]            k_reg;
  logic [BI_W-1:0]           scan_idx;
  logic                      root_rej;
  logic                      dup;
  logic [SLOT_W-1:0]         pos;
  logic                      took;
  logic [SLOT_W-1:0]         rd_slot;

  logic                      res_valid;
  logic                      res_accepted;
  logic                      res_is_entry;
  logic [ID_BITS-1:0]        res_id;
  logic [DW-1:0]             res_dist;
  logic                      res_new;
  logic                      res_last;

  knh_pkg::store_cmd_t       cmd;
  logic [BI_W-1:0]           rd_even_idx;
  logic [BI_W-1:0]           rd_odd_idx;
  logic [SLOT_W-1:0]         wr_slot;
  logic [EW-1:0]             wr_data;
  logic [EW-1:0]             even_q;
  logic [EW-1:0]             odd_q;

  logic                      accept;
  logic                      out_free;
  logic                      res_load;
  logic                      cfg_write;
  logic [CW-1:0]             nc_w;
  logic [CW-1:0]             k_w;
  logic [K_W-1:0]            k_eff;
  logic [CW-1:0]             k_c;

  logic [DW-1:0]             e_dist;
  logic [ID_BITS-1:0]        e_id;
  logic [DW-1:0]             o_dist;
  logic [ID_BITS-1:0]        o_id;

  logic                      odd_in;
  logic                      scan_done;
  logic                      root_now;
  logic                      dup_now;
  logic                      scan_rej;

  logic [CW-1:0]             lc;
  logic [CW-1:0]             rc;
  logic                      go_l;
  logic                      go_r;
  logic [CW-1:0]             sift_np;
  logic                      rd_last;

  knh_store #(.MAX_NEIGHBORS(MAX_NEIGHBORS), .ID_BITS(ID_BITS)) u_store (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .rd_even_idx  (rd_even_idx),
    .rd_odd_idx   (rd_odd_idx),
    .wr_slot      (wr_slot),
    .wr_data      (wr_data),
    .rd_even_data (even_q),
    .rd_odd_data  (odd_q)
  );

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite &&
                     (paddr[knh_pkg::PADDR_W-1] == knh_pkg::REG_NEIGHBOR_COUNT);
  assign prdata    = (paddr[knh_pkg::PADDR_W-1] == knh_pkg::REG_NEIGHBOR_COUNT) ?
                     knh_pkg::PDATA_W'(neighbor_count) : '0;

  assign nc_w  = CW'(neighbor_count);
  assign k_w   = (nc_w == '0) ? CW'(1) :
                 (nc_w > CW'(MAX_NEIGHBORS)) ? CW'(MAX_NEIGHBORS) : nc_w;
  assign k_eff = k_w[K_W-1:0];
  assign k_c   = CW'(k_reg);

  assign offer.ready = (state == S_IDLE);
  assign accept      = offer.valid && offer.ready;
  assign out_free    = !res_valid || result.ready;
  assign res_load    = out_free && ((state == S_RESULT) || (state == S_RD_WAIT));

  assign e_dist = even_q[EW-1 -: DW];
  assign e_id   = even_q[ID_BITS:1];
  assign o_dist = odd_q[EW-1 -: DW];
  assign o_id   = odd_q[ID_BITS:1];

  assign odd_in    = CW'({scan_idx, 1'b1}) < k_c;
  assign scan_done = CW'(scan_idx) == ((k_c - CW'(1)) >> 1);
  assign root_now  = (scan_idx == '0) ? (cand_dist >= e_dist) : root_rej;
  assign dup_now   = dup || (e_id == cand_id) || (odd_in && (o_id == cand_id));
  assign scan_rej  = root_now || dup_now;

  assign lc      = (CW'(pos) << 1) + CW'(1);
  assign rc      = lc + CW'(1);
  assign go_l    = (lc < k_c) && (o_dist > cand_dist);
  assign go_r    = (rc < k_c) && (e_dist > (go_l ? o_dist : cand_dist));
  assign sift_np = go_r ? rc : lc;
  assign rd_last = CW'(rd_slot) == (k_c - CW'(1));

  always_comb begin
    logic [CW-1:0] np;
    logic [CW-1:0] np_p1;
    logic [CW-1:0] rs_idx;
    logic          issue_children;
    cmd            = '0;
    rd_even_idx    = '0;
    rd_odd_idx     = '0;
    wr_slot        = pos;
    wr_data        = {cand_dist, cand_id, 1'b1};
    np             = '0;
    issue_children = 1'b0;
    rs_idx         = (CW'(rd_slot) + CW'(1)) >> 1;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.rd_en = 1'b1;
          cmd.clear = offer.first;
        end
      end
      S_SCAN: begin
        if (!scan_done) begin
          cmd.rd_en   = 1'b1;
          rd_even_idx = scan_idx + BI_W'(1);
          rd_odd_idx  = scan_idx + BI_W'(1);
        end else if (!scan_rej) begin
          issue_children = 1'b1;
        end
      end
      S_SIFT: begin
        cmd.wr_en = 1'b1;
        if (go_l || go_r) begin
          wr_data        = go_r ? even_q : odd_q;
          np             = sift_np;
          issue_children = 1'b1;
        end
      end
      S_RESULT: begin
        if (out_free && last_q) begin
          cmd.rd_en = 1'b1;
        end
      end
      S_RD_WAIT: begin
        if (out_free && !rd_last) begin
          cmd.rd_en   = 1'b1;
          rd_even_idx = rs_idx[BI_W-1:0];
          rd_odd_idx  = rs_idx[BI_W-1:0];
        end
      end
      default: begin
      end
    endcase
    np_p1 = np + CW'(1);
    if (issue_children) begin
      cmd.rd_en   = 1'b1;
      rd_odd_idx  = (((np << 1) + CW'(1)) < k_c) ? np[BI_W-1:0] : '0;
      rd_even_idx = (((np << 1) + CW'(2)) < k_c) ? np_p1[BI_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      neighbor_count <= knh_pkg::NEIGHBOR_COUNT_RESET;
      res_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        neighbor_count <= pwdata[knh_pkg::CNT_W-1:0];
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cand_id   <= offer.candidate_id;
            cand_dist <= offer.distance;
            last_q    <= offer.last;
            k_reg     <= k_eff;
            scan_idx  <= '0;
            root_rej  <= 1'b0;
            dup       <= 1'b0;
            took      <= 1'b0;
            state     <= (offer.candidate_id == EMPTY_ID) ? S_RESULT : S_SCAN;
          end
        end
        S_SCAN: begin
          if (!scan_done) begin
            scan_idx <= scan_idx + BI_W'(1);
            root_rej <= root_now;
            dup      <= dup_now;
          end else if (scan_rej) begin
            took  <= 1'b0;
            state <= S_RESULT;
          end else begin
            pos   <= '0;
            state <= S_SIFT;
          end
        end
        S_SIFT: begin
          if (go_l || go_r) begin
            pos <= sift_np[SLOT_W-1:0];
          end else begin
            took  <= 1'b1;
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            res_accepted <= took;
            res_is_entry <= 1'b0;
            res_id       <= '0;
            res_dist     <= '0;
            res_new      <= 1'b0;
            res_last     <= !last_q;
            rd_slot      <= '0;
            state        <= last_q ? S_RD_WAIT : S_IDLE;
          end
        end
        S_RD_WAIT: begin
          if (out_free) begin
            res_accepted <= 1'b0;
            res_is_entry <= 1'b1;
            res_id       <= rd_slot[0] ? o_id : e_id;
            res_dist     <= rd_slot[0] ? o_dist : e_dist;
            res_new      <= rd_slot[0] ? odd_q[0] : even_q[0];
            res_last     <= rd_last;
            if (rd_last) begin
              state <= S_IDLE;
            end else begin
              rd_slot <= rd_slot + SLOT_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid          = res_valid;
  assign result.accepted       = res_accepted;
  assign result.is_entry       = res_is_entry;
  assign result.entry_id       = res_id;
  assign result.entry_distance = res_dist;
  assign result.entry_new      = res_new;
  assign result.last_of_run    = res_last;

  a_empty_id_rejected: assert property (@(posedge clk) disable iff (rst)
    accept && (offer.candidate_id == EMPTY_ID) |=> (state == S_RESULT) && !took)
    else $error("empty id offer not rejected");

  a_entry_not_accepted: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.is_entry |-> !result.accepted)
    else $error("heap entry transaction flagged as accepted");

  a_readout_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RD_WAIT |-> CW'(rd_slot) < k_c)
    else $error("readout slot beyond neighbor count");

  a_write_only_in_sift: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> (state == S_SIFT) && (CW'(pos) < k_c))
    else $error("heap write outside sift or beyond neighbor count");

endmodule

/* tb/sv/knh_heap_checker.sv */
`timescale 1ns / 100ps

module knh_heap_checker
  import knh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  knh_in_if                  offer,
  knh_out_if                 result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  output int                 mismatches,
  output int                 outstanding
);

  localparam int HEAP_SLOTS = MAX_NEIGHBORS_DEF;
  localparam int IDW = ID_BITS_DEF;
  localparam logic [IDW-1:0] EMPTY_ID = '1;

  typedef struct packed {
    logic              accepted;
    logic              is_entry;
    logic [IDW-1:0]    entry_id;
    logic [DIST_W-1:0] entry_distance;
    logic              entry_new;
    logic              last_of_run;
  } heap_result_t;

  logic [DIST_W-1:0] slot_dist [HEAP_SLOTS];
  logic [IDW-1:0]    slot_id [HEAP_SLOTS];
  logic              slot_new [HEAP_SLOTS];
  logic [CNT_W-1:0]  k_reg;
  heap_result_t      awaited_results [$];
  int                results_seen;

  task automatic clear_slots();
    int s;
    for (s = 0; s < HEAP_SLOTS; s++) begin
      slot_dist[s] = FAR_BITS;
      slot_id[s] = EMPTY_ID;
      slot_new[s] = 1'b1;
    end
  endtask

  task automatic apply_offer(input logic [IDW-1:0] id, input logic [DIST_W-1:0] offer_dist,
                             input logic first_flag, input logic last_flag);
    int k, s, pos, lc, rc, big;
    logic took, done, tn;
    logic [DIST_W-1:0] td;
    logic [IDW-1:0] ti;
    heap_result_t r;
    k = (k_reg == 0) ? 1 : (k_reg > HEAP_SLOTS) ? HEAP_SLOTS : int'(k_reg);
    if (first_flag) clear_slots();
    took = (id != EMPTY_ID) && (offer_dist < slot_dist[0]);
    for (s = 0; s < k; s++) begin
      if (slot_id[s] == id) took = 1'b0;
    end
    if (took) begin
      slot_dist[0] = offer_dist;
      slot_id[0] = id;
      slot_new[0] = 1'b1;
      pos = 0;
      done = 1'b0;
      while (!done) begin
        lc = 2 * pos + 1;
        rc = lc + 1;
        big = pos;
        if (lc < k && slot_dist[lc] > slot_dist[big]) big = lc;
        if (rc < k && slot_dist[rc] > slot_dist[big]) big = rc;
        if (big == pos) begin
          done = 1'b1;
        end else begin
          td = slot_dist[pos]; slot_dist[pos] = slot_dist[big]; slot_dist[big] = td;
          ti = slot_id[pos]; slot_id[pos] = slot_id[big]; slot_id[big] = ti;
          tn = slot_new[pos]; slot_new[pos] = slot_new[big]; slot_new[big] = tn;
          pos = big;
        end
      end
    end
    r = '0;
    r.accepted = took;
    r.last_of_run = !last_flag;
    awaited_results.push_back(r);
    if (last_flag) begin
      for (s = 0; s < k; s++) begin
        r = '0;
        r.is_entry = 1'b1;
        r.entry_id = slot_id[s];
        r.entry_distance = slot_dist[s];
        r.entry_new = slot_new[s];
        r.last_of_run = (s == k - 1);
        awaited_results.push_back(r);
      end
    end
  endtask

  task automatic check_result();
    heap_result_t got, want;
    logic bad;
    got.accepted = result.accepted;
    got.is_entry = result.is_entry;
    got.entry_id = result.entry_id;
    got.entry_distance = result.entry_distance;
    got.entry_new = result.entry_new;
    got.last_of_run = result.last_of_run;
    if (awaited_results.size() == 0) begin
      if (mismatches < 10)
        $display("result %0d: none awaited, got acc=%0d entry=%0d id=%h dist=%h new=%0d last=%0d",
                 results_seen, got.accepted, got.is_entry, got.entry_id,
                 got.entry_distance, got.entry_new, got.last_of_run);
      mismatches++;
    end else begin
      want = awaited_results.pop_front();
      bad = (got.accepted !== want.accepted) || (got.is_entry !== want.is_entry) ||
            (got.entry_id !== want.entry_id) || (got.entry_distance !== want.entry_distance) ||
            (got.entry_new !== want.entry_new) || (got.last_of_run !== want.last_of_run);
      if (bad) begin
        if (mismatches < 10)
          $display({"result %0d: expected acc=%0d entry=%0d id=%h dist=%h new=%0d last=%0d,",
                    " got acc=%0d entry=%0d id=%h dist=%h new=%0d last=%0d"},
                   results_seen, want.accepted, want.is_entry, want.entry_id,
                   want.entry_distance, want.entry_new, want.last_of_run,
                   got.accepted, got.is_entry, got.entry_id,
                   got.entry_distance, got.entry_new, got.last_of_run);
        mismatches++;
      end
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_slots();
      k_reg = NEIGHBOR_COUNT_RESET;
      awaited_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_NEIGHBOR_COUNT)
        k_reg = pwdata[CNT_W-1:0];
      if (offer.valid && offer.ready)
        apply_offer(offer.candidate_id, offer.distance, offer.first, offer.last);
      if (result.valid && result.ready) check_result();
    end
    outstanding <= awaited_results.size();
  end

endmodule

/* tb/sv/k_nearest_bounded_max_heap_test.sv */
`timescale 1ns / 100ps

module k_nearest_bounded_max_heap_test;
  import knh_pkg::*;

  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 42;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [PADDR_W-1:0] COUNT_ADDR = {REG_NEIGHBOR_COUNT, 2'b00};
  localparam logic [PADDR_W-1:0] UNUSED_ADDR = {1'b1, 2'b00};
  localparam logic [ID_BITS_DEF-1:0] EMPTY_ID = '1;
  localparam logic [ID_BITS_DEF-1:0] TOP_ID = EMPTY_ID - ID_BITS_DEF'(1);
  localparam logic [DIST_W-1:0] INF_BITS = 31'h7F800000;
  localparam logic [DIST_W-1:0] TOP_BITS = '1;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  knh_in_if  offer_ch ();
  knh_out_if result_ch ();

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  bit steady = 1'b0;
  bit squeeze_request = 1'b0;
  bit hold_results = 1'b0;
  int count_plan [PHASES] = '{16, 1, 0, 31, 17, 2, 9, 16, 5, 3};

  k_nearest_bounded_max_heap dut (
    .clk     (clk),
    .rst     (rst),
    .offer   (offer_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  knh_heap_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .offer       (offer_ch),
    .result      (result_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    offer_ch.valid = 1'b0;
    offer_ch.candidate_id = '0;
    offer_ch.distance = '0;
    offer_ch.first = 1'b0;
    offer_ch.last = 1'b0;
    result_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    result_ch.ready <= !hold_results && (steady || $urandom_range(99) >= 20);
  end

  // hold the result side off so the block backs up into its offer port
  initial begin
    wait (squeeze_request);
    @(posedge clk);
    hold_results <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_results <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [ID_BITS_DEF-1:0] pick_id();
    int roll;
    roll = $urandom_range(99);
    if (roll < 65) return ID_BITS_DEF'($urandom_range(40));
    if (roll < 95) return ID_BITS_DEF'($urandom());
    return EMPTY_ID;
  endfunction

  function automatic logic [DIST_W-1:0] pick_dist();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return DIST_W'($urandom_range(2000));
    if (roll < 75) return DIST_W'($urandom());
    if (roll < 90) return FAR_BITS - DIST_W'(2) + DIST_W'($urandom_range(4));
    return INF_BITS | DIST_W'($urandom_range(23'h7FFFFF));
  endfunction

  task automatic send_offer(input logic [ID_BITS_DEF-1:0] id,
                            input logic [DIST_W-1:0] offer_dist,
                            input logic first_flag, input logic last_flag);
    while (!steady && $urandom_range(99) < 20) begin
      offer_ch.valid <= 1'b0;
      @(posedge clk);
    end
    offer_ch.valid <= 1'b1;
    offer_ch.candidate_id <= id;
    offer_ch.distance <= offer_dist;
    offer_ch.first <= first_flag;
    offer_ch.last <= last_flag;
    do @(posedge clk); while (!offer_ch.ready);
  endtask

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain_results();
    offer_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int items, input bit fresh_start);
    int left, run_len, i;
    bit open_run;
    logic first_flag, last_flag;
    left = items;
    open_run = fresh_start;
    while (left > 0) begin
      run_len = $urandom_range(1, 40);
      if (run_len > left) run_len = left;
      for (i = 0; i < run_len; i++) begin
        first_flag = open_run && (i == 0);
        last_flag = (i == run_len - 1);
        if ($urandom_range(99) < 8) begin
          first_flag = 1'($urandom_range(1));
          last_flag = 1'($urandom_range(1));
        end
        send_offer(pick_id(), pick_dist(), first_flag, last_flag);
      end
      left -= run_len;
      open_run = ($urandom_range(99) < 90);
    end
  endtask

  initial begin
    int p;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    write_reg(COUNT_ADDR, 32'd4);
    send_offer(20'd0, 31'd0, 1'b1, 1'b0);
    send_offer(TOP_ID, INF_BITS, 1'b0, 1'b0);
    send_offer(EMPTY_ID, 31'd5, 1'b0, 1'b0);
    send_offer(20'd0, 31'd1, 1'b0, 1'b0);
    send_offer(20'd7, FAR_BITS, 1'b0, 1'b0);
    send_offer(20'd8, FAR_BITS - DIST_W'(1), 1'b0, 1'b0);
    send_offer(20'd9, TOP_BITS, 1'b0, 1'b0);
    send_offer(20'd10, 31'd500, 1'b0, 1'b0);
    send_offer(20'd11, 31'd300, 1'b0, 1'b0);
    send_offer(20'd12, 31'd400, 1'b0, 1'b0);
    send_offer(20'd13, 31'd500, 1'b0, 1'b0);
    send_offer(20'd14, 31'd499, 1'b0, 1'b0);
    send_offer(20'd0, 31'd0, 1'b0, 1'b1);
    send_offer(20'd5, 31'd100, 1'b1, 1'b1);
    drain_results();

    write_reg(COUNT_ADDR, 32'd16);
    send_offer(20'h55555, 31'h2AAAAAAA, 1'b1, 1'b0);
    send_offer(20'hAAAAA, 31'h55555555, 1'b0, 1'b0);
    send_offer(20'd3, 31'd0, 1'b0, 1'b1);

    for (p = 0; p < PHASES; p++) begin
      drain_results();
      if (p == 2) write_reg(UNUSED_ADDR, 32'd2);
      write_reg(COUNT_ADDR, count_plan[p]);
      steady = (p == 4);
      if (p == 1) squeeze_request = 1'b1;
      run_phase(ITEMS_PER_PHASE, p == 0 || $urandom_range(1) == 1);
    end
    steady = 1'b0;
    drain_results();

    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
